FILE: src/srap_pkg.sv
// Shared types and constants of the STUN response address parser.
package srap_pkg;

	// Widest byte offset that a header plus a full declared section can reach.
	localparam int POS_W = 17;

	localparam logic [POS_W-1:0] HEADER_BYTES    = 17'd20;
	localparam logic [15:0]      MIN_SECTION     = 16'd12;
	localparam logic [15:0]      CLASS_MASK      = 16'h0110;
	localparam logic [15:0]      CLASS_SUCCESS   = 16'h0100;
	localparam logic [15:0]      ATTR_MAPPED     = 16'h0001;
	localparam logic [15:0]      ATTR_XOR_MAPPED = 16'h0020;
	localparam logic [15:0]      ADDR_MIN_LENGTH = 16'd8;
	localparam logic [7:0]       FAMILY_IPV4     = 8'h01;
	localparam logic [31:0]      COOKIE_VALUE    = 32'h2112A442;
	localparam logic [15:0]      PORT_MASK       = 16'h2112;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_SHORT       = 2'd1,
		STATUS_NOT_SUCCESS = 2'd2,
		STATUS_BAD_LENGTH  = 2'd3
	} status_t;

	// One received byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// One parse result.
	typedef struct packed {
		logic [1:0]  status;
		logic        address_found;
		logic        used_xor;
		logic [15:0] message_type;
		logic [15:0] message_length;
		logic [31:0] msg_cookie;
		logic [63:0] transaction_id_high;
		logic [31:0] transaction_id_low;
		logic [7:0]  address_family;
		logic [15:0] mapped_port;
		logic [31:0] mapped_ip;
	} result_t;

	// A classified byte handed from the front part to the back part.
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             last_byte;
		logic             taken;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] len;
	} cmd_t;

endpackage

FILE: src/srap_chan_if.sv
// Valid/ready channel carrying one payload item per request.
interface srap_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/srap_front.sv
// Front part: accepts datagram bytes, counts them and marks dropped bytes.
module srap_front #(
	parameter int MAX_DATAGRAM_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	srap_chan_if.sink     datagram,
	srap_chan_if.source   cmd
);
	localparam int CW = $clog2(MAX_DATAGRAM_BYTES + 1);
	localparam int PW = srap_pkg::POS_W;

	logic [CW-1:0] count_q;
	logic          taken;
	logic          fire;

	assign taken = count_q < CW'(MAX_DATAGRAM_BYTES);
	assign fire  = datagram.valid && datagram.ready;

	assign datagram.ready      = cmd.ready;
	assign cmd.valid           = datagram.valid;
	assign cmd.data.data_byte  = datagram.data.data_byte;
	assign cmd.data.last_byte  = datagram.data.last_byte;
	assign cmd.data.taken      = taken;
	assign cmd.data.pos        = PW'(count_q);
	assign cmd.data.len        = taken ? PW'(count_q) + PW'(1) : PW'(MAX_DATAGRAM_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			if (datagram.data.last_byte) begin
				count_q <= '0;
			end else if (taken) begin
				count_q <= count_q + CW'(1);
			end
		end
	end
endmodule

FILE: src/srap_queue.sv
// Two-entry queue between the front and back parts.
module srap_queue (
	input  logic          clk,
	input  logic          arst_n,
	srap_chan_if.sink     push,
	srap_chan_if.source   pop
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	srap_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push.ready = cnt_q != CNT_W'(DEPTH);
	assign pop.valid  = cnt_q != '0;
	assign pop.data   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end
endmodule

FILE: src/srap_back.sv
// Back part: header capture, attribute walk and result register.
module srap_back (
	input  logic          clk,
	input  logic          arst_n,
	srap_chan_if.sink     cmd,
	srap_chan_if.source   result
);
	localparam int PW = srap_pkg::POS_W;

	typedef struct packed {
		logic [15:0]   header_type;
		logic [15:0]   header_length;
		logic [31:0]   cookie;
		logic [63:0]   txid_hi;
		logic [31:0]   txid_lo;
		logic [PW-1:0] attr_start;
		logic [15:0]   sect_rem;
		logic [15:0]   attr_type;
		logic [15:0]   attr_len;
		logic          walk_done;
		logic          found;
		logic          xor_f;
		logic [7:0]    family;
		logic [15:0]   port;
		logic [31:0]   ip;
	} walk_t;

	function automatic walk_t walk_reset();
		walk_t w;
		w            = '0;
		w.attr_start = srap_pkg::HEADER_BYTES;
		return w;
	endfunction

	walk_t              st_q;
	walk_t              nx;
	srap_pkg::result_t  res;
	srap_pkg::result_t  out_q;
	logic               out_valid_q;
	logic [PW-1:0]      p;
	logic [PW-1:0]      off;
	logic [PW-1:0]      step;
	logic [7:0]         b;
	logic [15:0]        new_len;
	logic [15:0]        hdr_len_new;
	logic [15:0]        adv_len;
	logic [31:0]        ip_new;
	logic               addr_type;
	logic               do_adv;
	logic               can_take;
	logic               fire;

	assign p    = cmd.data.pos;
	assign b    = cmd.data.data_byte;
	assign can_take  = !cmd.data.last_byte || !out_valid_q || result.ready;
	assign cmd.ready = can_take;
	assign fire      = cmd.valid && can_take;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		nx          = st_q;
		do_adv      = 1'b0;
		off         = '0;
		new_len     = {st_q.attr_len[7:0], b};
		hdr_len_new = {st_q.header_length[7:0], b};
		ip_new      = {st_q.ip[23:0], b};
		adv_len     = st_q.attr_len;
		addr_type   = (st_q.attr_type == srap_pkg::ATTR_MAPPED) ||
			(st_q.attr_type == srap_pkg::ATTR_XOR_MAPPED);
		if (cmd.data.taken) begin
			if (p < PW'(2)) begin
				nx.header_type = {st_q.header_type[7:0], b};
			end else if (p < PW'(4)) begin
				nx.header_length = hdr_len_new;
				if (p == PW'(3)) begin
					nx.sect_rem = hdr_len_new;
					if (hdr_len_new == '0) begin
						nx.walk_done = 1'b1;
					end
				end
			end else if (p < PW'(8)) begin
				nx.cookie = {st_q.cookie[23:0], b};
			end else if (p < PW'(16)) begin
				nx.txid_hi = {st_q.txid_hi[55:0], b};
			end else if (p < srap_pkg::HEADER_BYTES) begin
				nx.txid_lo = {st_q.txid_lo[23:0], b};
			end else if (!st_q.walk_done && p >= st_q.attr_start) begin
				off = p - st_q.attr_start;
				if (off < PW'(2)) begin
					nx.attr_type = {st_q.attr_type[7:0], b};
				end else if (off < PW'(4)) begin
					nx.attr_len = new_len;
					if (off == PW'(3)) begin
						if (new_len == '0) begin
							nx.walk_done = 1'b1;
						end else if (new_len < srap_pkg::ADDR_MIN_LENGTH || !addr_type) begin
							do_adv  = 1'b1;
							adv_len = new_len;
						end
					end
				end else if (off == PW'(5)) begin
					nx.family = b;
					if (b != srap_pkg::FAMILY_IPV4) begin
						do_adv = 1'b1;
					end
				end else if (off == PW'(6) || off == PW'(7)) begin
					nx.port = {st_q.port[7:0], b};
				end else if (off >= PW'(8) && off <= PW'(11)) begin
					nx.ip = ip_new;
					if (off == PW'(11)) begin
						nx.found     = 1'b1;
						nx.walk_done = 1'b1;
						nx.xor_f     = st_q.attr_type == srap_pkg::ATTR_XOR_MAPPED;
						if (st_q.attr_type == srap_pkg::ATTR_XOR_MAPPED) begin
							nx.port = st_q.port ^ srap_pkg::PORT_MASK;
							nx.ip   = ip_new ^ srap_pkg::COOKIE_VALUE;
						end
					end
				end
			end
		end
		// Skip to the next attribute, or close the walk once the section is spent.
		step = PW'(4) + PW'(adv_len);
		if (do_adv) begin
			if (step >= PW'(st_q.sect_rem)) begin
				nx.walk_done = 1'b1;
				nx.sect_rem  = '0;
			end else begin
				nx.sect_rem   = st_q.sect_rem - step[15:0];
				nx.attr_start = st_q.attr_start + step;
			end
		end
	end

	always_comb begin
		res = '0;
		if (cmd.data.len < srap_pkg::HEADER_BYTES) begin
			res.status = srap_pkg::STATUS_SHORT;
		end else if ((nx.header_type & srap_pkg::CLASS_MASK) != srap_pkg::CLASS_SUCCESS) begin
			res.status       = srap_pkg::STATUS_NOT_SUCCESS;
			res.message_type = nx.header_type;
		end else if (nx.header_length < srap_pkg::MIN_SECTION ||
				PW'(nx.header_length) + srap_pkg::HEADER_BYTES > cmd.data.len) begin
			res.status         = srap_pkg::STATUS_BAD_LENGTH;
			res.message_type   = nx.header_type;
			res.message_length = nx.header_length;
		end else begin
			res.status              = srap_pkg::STATUS_OK;
			res.address_found       = nx.found;
			res.used_xor            = nx.found && nx.xor_f;
			res.message_type        = nx.header_type;
			res.message_length      = nx.header_length;
			res.msg_cookie          = nx.cookie;
			res.transaction_id_high = nx.txid_hi;
			res.transaction_id_low  = nx.txid_lo;
			res.address_family      = nx.family;
			res.mapped_port         = nx.found ? nx.port : '0;
			res.mapped_ip           = nx.found ? nx.ip : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cmd.data.last_byte) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= walk_reset();
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				st_q <= cmd.data.last_byte ? walk_reset() : nx;
			end
			if (fire && cmd.data.last_byte) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

FILE: src/stun_response_address_parser.sv
// Top level of the STUN binding response parser.
//
// The datagram channel takes one received byte per request, in arrival order,
// with last_byte set on the final byte. The result channel gives one request
// per datagram: status, the 20-byte header fields and the first IPv4 MAPPED or
// XOR-MAPPED address found in the attribute section, unmasked for the XOR form.
//
// Throughput is one byte per cycle but for result stalls. The front part counts
// bytes and drops those past MAX_DATAGRAM_BYTES; a two-entry queue separates it
// from the back part, which walks the header and attributes at one byte per
// cycle. The output register loads once the last byte has left the queue and
// holds the result until the receiver takes it.
//
// When the receiver stalls, bytes of the next datagram keep flowing into the
// back part; only the last byte of a datagram waits for the output register,
// after which the queue fills and datagram.ready drops.
//
// Asynchronous reset clears the byte counter, the queue, the walk state and
// the result valid flag; the block is ready for a datagram right after reset.
module stun_response_address_parser #(
	parameter int MAX_DATAGRAM_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	srap_chan_if.sink     datagram,
	srap_chan_if.source   result
);
	// Front to queue, and queue to back.
	srap_chan_if #(.payload_t(srap_pkg::cmd_t)) front_cmd ();
	srap_chan_if #(.payload_t(srap_pkg::cmd_t)) back_cmd ();

	srap_front #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.datagram (datagram),
		.cmd      (front_cmd)
	);

	srap_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_cmd),
		.pop    (back_cmd)
	);

	srap_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (back_cmd),
		.result (result)
	);
endmodule

FILE: src/srap_checker.sv
// Port-level checks of the parser, bound to its top level.
module srap_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input srap_pkg::result_t out_data
);
	logic [3:0] pending_q;
	logic       in_last_fire;
	logic       out_fire;

	assign in_last_fire = in_valid && in_ready && in_last;
	assign out_fire     = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last_fire && !out_fire) begin
			pending_q <= pending_q + 4'd1;
		end else if (out_fire && !in_last_fire) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_result_has_datagram: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> pending_q != 4'd0)
		else $error("result without a finished datagram");

	a_error_no_address: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != srap_pkg::STATUS_OK |->
		!out_data.address_found && !out_data.used_xor &&
		out_data.mapped_port == '0 && out_data.mapped_ip == '0)
		else $error("address reported on an error status");

	a_xor_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.used_xor |-> out_data.address_found)
		else $error("xor flag without an address");

	a_ok_header_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == srap_pkg::STATUS_OK |->
		out_data.message_length >= srap_pkg::MIN_SECTION &&
		(out_data.message_type & srap_pkg::CLASS_MASK) == srap_pkg::CLASS_SUCCESS)
		else $error("ok status on a malformed header");
endmodule

bind stun_response_address_parser srap_checker u_srap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (datagram.valid),
	.in_ready  (datagram.ready),
	.in_last   (datagram.data.last_byte),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
